/* src/clqm_pkg.sv */
`timescale 1ns / 1ps

package clqm_pkg;

   localparam int NODE_COUNT_DEFAULT = 16;

   localparam int OPERATION_W = 1;
   localparam int NODE_INDEX_W = 4;
   localparam int STATUS_W = 2;
   localparam int MEMBER_COUNT_W = 5;
   localparam int HEAD_NODE_W = 4;

   typedef enum logic [OPERATION_W-1:0] {
      OP_APPEND = 1'b0,
      OP_REMOVE = 1'b1
   } clqm_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_QUEUED = 2'd1,
      STATUS_EMPTY  = 2'd2,
      STATUS_ABSENT = 2'd3
   } clqm_status_type;

   // Link update that the datapath performs in the current cycle.
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_APPEND_FIRST,
      ACT_APPEND_LINK,
      ACT_APPEND_CLOSE,
      ACT_REMOVE_LAST,
      ACT_REMOVE_LINK
   } clqm_action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_APPEND_TAIL,
      ST_DONE
   } clqm_state_type;

   typedef struct packed {
      logic            load_item;
      logic            latch_status;
      clqm_action_type action;
      logic            load_result;
   } clqm_cmd_type;

   typedef struct packed {
      clqm_action_type plan;
      logic            result_free;
   } clqm_stat_type;

endpackage

/* src/clqm_channels.sv */
`timescale 1ns / 1ps

interface clqm_req_if;
   logic                              valid;
   logic                              ready;
   logic [clqm_pkg::OPERATION_W-1:0]  operation;
   logic [clqm_pkg::NODE_INDEX_W-1:0] node_index;

   modport source (output valid, output operation, output node_index, input ready);
   modport sink (input valid, input operation, input node_index, output ready);
endinterface

interface clqm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [clqm_pkg::STATUS_W-1:0]       status;
   logic [clqm_pkg::MEMBER_COUNT_W-1:0] member_count;
   logic [clqm_pkg::HEAD_NODE_W-1:0]    head_node;
   logic                                head_valid;

   modport source (output valid, output status, output member_count, output head_node,
                   output head_valid, input ready);
   modport sink (input valid, input status, input member_count, input head_node,
                 input head_valid, output ready);
endinterface

/* src/circular_linked_queue_manager_unit.sv */
`timescale 1ns / 1ps

// Circular doubly linked queue over a pool of nodes named by index. Each
// request beat appends a node at the tail or removes a named node, and each
// gives one response beat with status, member count and head. An append to a
// nonempty queue passes through an extra tail-link state (ST_APPEND_TAIL),
// and a response waits in ST_DONE until the output register is free. A new
// request is accepted only after the previous one has loaded its response;
// the successor and predecessor link memories each have one read and one
// write port. A finished response sits in an output register while the next
// request is accepted. No clearing pass is needed after reset.
module circular_linked_queue_manager_unit #(
   parameter int NODE_COUNT = clqm_pkg::NODE_COUNT_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   clqm_req_if.sink  req_bus,
   clqm_rsp_if.source rsp_bus
);
   import clqm_pkg::*;

   clqm_cmd_type  cmd;
   clqm_stat_type stat;

   clqm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   clqm_datapath #(
      .NODE_COUNT (NODE_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_bus.operation),
      .req_node_index   (req_bus.node_index),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_status       (rsp_bus.status),
      .rsp_member_count (rsp_bus.member_count),
      .rsp_head_node    (rsp_bus.head_node),
      .rsp_head_valid   (rsp_bus.head_valid)
   );

endmodule

/* src/clqm_controller.sv */
`timescale 1ns / 1ps

module clqm_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  clqm_pkg::clqm_stat_type stat,
   output clqm_pkg::clqm_cmd_type  cmd
);
   import clqm_pkg::*;

   clqm_state_type state_ff;
   clqm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      cmd.load_item    = 1'b0;
      cmd.latch_status = 1'b0;
      cmd.action       = ACT_NONE;
      cmd.load_result  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.latch_status = 1'b1;
            cmd.action       = stat.plan;
            // Appending behind an existing tail needs a further write, made in ST_APPEND_TAIL.
            if (stat.plan == ACT_APPEND_LINK) begin
               state_in = ST_APPEND_TAIL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_APPEND_TAIL: begin
            cmd.action = ACT_APPEND_CLOSE;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (stat.result_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/clqm_datapath.sv */
`timescale 1ns / 1ps

module clqm_datapath #(
   parameter int NODE_COUNT = clqm_pkg::NODE_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [clqm_pkg::OPERATION_W-1:0]    req_operation,
   input  logic [clqm_pkg::NODE_INDEX_W-1:0]   req_node_index,
   input  clqm_pkg::clqm_cmd_type              cmd,
   output clqm_pkg::clqm_stat_type             stat,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [clqm_pkg::STATUS_W-1:0]       rsp_status,
   output logic [clqm_pkg::MEMBER_COUNT_W-1:0] rsp_member_count,
   output logic [clqm_pkg::HEAD_NODE_W-1:0]    rsp_head_node,
   output logic                                rsp_head_valid
);
   import clqm_pkg::*;

   // Only nodes that the index field can name are ever stored.
   localparam int ADDRESSABLE = 1 << NODE_INDEX_W;
   localparam int POOL = (NODE_COUNT < ADDRESSABLE) ? NODE_COUNT : ADDRESSABLE;
   localparam int IDX_W = $clog2(POOL);
   localparam int CNT_W = $clog2(POOL + 1);

   logic [IDX_W-1:0] next_mem [POOL];
   logic [IDX_W-1:0] prev_mem [POOL];

   clqm_op_type                op_ff;
   logic [NODE_INDEX_W-1:0]    node_ff;
   logic [IDX_W-1:0]           next_rd_ff;
   logic [IDX_W-1:0]           prev_rd_ff;
   logic [IDX_W-1:0]           tail_ff;
   clqm_status_type            status_ff;
   logic [IDX_W-1:0]           head_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [POOL-1:0]            member_ff;
   logic                       rsp_valid_ff;
   clqm_status_type            rsp_status_ff;
   logic [CNT_W-1:0]           rsp_count_ff;
   logic [IDX_W-1:0]           rsp_head_ff;

   logic [IDX_W-1:0]           req_idx;
   logic [IDX_W-1:0]           node_idx;
   logic                       in_range;
   logic                       member_hit;
   logic                       empty;
   logic                       single;
   clqm_status_type            status_c;
   clqm_action_type            plan_c;
   logic                       next_we;
   logic [IDX_W-1:0]           next_wa;
   logic [IDX_W-1:0]           next_wd;
   logic                       prev_we;
   logic [IDX_W-1:0]           prev_wa;
   logic [IDX_W-1:0]           prev_wd;

   assign req_idx    = req_node_index[IDX_W-1:0];
   assign node_idx   = node_ff[IDX_W-1:0];
   assign in_range   = (int'(node_ff) < NODE_COUNT);
   assign member_hit = in_range && member_ff[node_idx];
   assign empty      = (count_ff == '0);
   assign single     = (count_ff == CNT_W'(1));

   // Classify the item held in the input register.
   always_comb begin
      status_c = STATUS_OK;
      plan_c   = ACT_NONE;
      unique case (op_ff)
         OP_APPEND: begin
            if (!in_range) begin
               status_c = STATUS_ABSENT;
            end else if (member_hit) begin
               status_c = STATUS_QUEUED;
            end else if (empty) begin
               plan_c = ACT_APPEND_FIRST;
            end else begin
               plan_c = ACT_APPEND_LINK;
            end
         end
         OP_REMOVE: begin
            if (empty) begin
               status_c = STATUS_EMPTY;
            end else if (!member_hit) begin
               status_c = STATUS_ABSENT;
            end else if (single) begin
               plan_c = ACT_REMOVE_LAST;
            end else begin
               plan_c = ACT_REMOVE_LINK;
            end
         end
         default: begin
            status_c = STATUS_OK;
         end
      endcase
   end

   assign stat.plan        = plan_c;
   assign stat.result_free = !rsp_valid_ff || rsp_ready;

   // Each link memory takes at most one write per cycle.
   always_comb begin
      next_we = 1'b0;
      next_wa = node_idx;
      next_wd = node_idx;
      prev_we = 1'b0;
      prev_wa = node_idx;
      prev_wd = node_idx;
      case (cmd.action)
         ACT_APPEND_FIRST: begin
            next_we = 1'b1;
            prev_we = 1'b1;
         end
         ACT_APPEND_LINK: begin
            next_we = 1'b1;
            next_wd = head_ff;
            prev_we = 1'b1;
            prev_wd = prev_rd_ff;
         end
         ACT_APPEND_CLOSE: begin
            next_we = 1'b1;
            next_wa = tail_ff;
            prev_we = 1'b1;
            prev_wa = head_ff;
         end
         ACT_REMOVE_LINK: begin
            next_we = 1'b1;
            next_wa = prev_rd_ff;
            next_wd = next_rd_ff;
            prev_we = 1'b1;
            prev_wa = next_rd_ff;
            prev_wd = prev_rd_ff;
         end
         default: begin
            next_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      // An append needs the predecessor of the head; a removal needs both
      // neighbors of the node itself.
      if (cmd.load_item) begin
         next_rd_ff <= next_mem[req_idx];
         if (clqm_op_type'(req_operation) == OP_APPEND) begin
            prev_rd_ff <= prev_mem[head_ff];
         end else begin
            prev_rd_ff <= prev_mem[req_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= clqm_op_type'(req_operation);
         node_ff <= req_node_index;
      end
      if (cmd.latch_status) begin
         status_ff <= status_c;
      end
      if (cmd.action == ACT_APPEND_LINK) begin
         tail_ff <= prev_rd_ff;
      end
      if (cmd.load_result) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
         rsp_head_ff   <= head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         member_ff <= '0;
      end else begin
         case (cmd.action)
            ACT_APPEND_FIRST: begin
               head_ff             <= node_idx;
               count_ff            <= count_ff + CNT_W'(1);
               member_ff[node_idx] <= 1'b1;
            end
            ACT_APPEND_CLOSE: begin
               count_ff            <= count_ff + CNT_W'(1);
               member_ff[node_idx] <= 1'b1;
            end
            ACT_REMOVE_LAST: begin
               head_ff             <= '0;
               count_ff            <= count_ff - CNT_W'(1);
               member_ff[node_idx] <= 1'b0;
            end
            ACT_REMOVE_LINK: begin
               if (head_ff == node_idx) begin
                  head_ff <= next_rd_ff;
               end
               count_ff            <= count_ff - CNT_W'(1);
               member_ff[node_idx] <= 1'b0;
            end
            default: begin
               head_ff <= head_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_member_count = MEMBER_COUNT_W'(rsp_count_ff);
   assign rsp_head_node    = HEAD_NODE_W'(rsp_head_ff);
   assign rsp_head_valid   = (rsp_count_ff != '0);

endmodule

/* bench/clqm_queue_checker.sv */
`timescale 1ns / 1ps

module clqm_queue_checker #(
   parameter int NODE_COUNT = clqm_pkg::NODE_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [clqm_pkg::OPERATION_W-1:0]    req_operation,
   input  logic [clqm_pkg::NODE_INDEX_W-1:0]   req_node_index,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [clqm_pkg::STATUS_W-1:0]       rsp_status,
   input  logic [clqm_pkg::MEMBER_COUNT_W-1:0] rsp_member_count,
   input  logic [clqm_pkg::HEAD_NODE_W-1:0]    rsp_head_node,
   input  logic                                rsp_head_valid,
   output int                                  replies_pending,
   output int                                  mismatch_count
);
   import clqm_pkg::*;

   typedef struct packed {
      clqm_status_type             status;
      logic [MEMBER_COUNT_W-1:0]   member_count;
      logic [HEAD_NODE_W-1:0]      head_node;
      logic                        head_valid;
   } queue_reply_type;

   logic [NODE_INDEX_W-1:0] succ_node [NODE_COUNT];
   logic [NODE_INDEX_W-1:0] pred_node [NODE_COUNT];
   logic [NODE_COUNT-1:0]   member_map;
   logic [NODE_INDEX_W-1:0] head_idx;
   int                      member_total;
   queue_reply_type         expected_replies [$];

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Unknown bits on the response count as a mismatch.
   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
      end
   endtask

   // Applies one request to the queue image and returns the reply it must produce.
   function automatic queue_reply_type apply_queue_op(input clqm_op_type op,
                                                      input logic [NODE_INDEX_W-1:0] node);
      queue_reply_type         reply;
      logic [NODE_INDEX_W-1:0] tail_idx;
      logic [NODE_INDEX_W-1:0] nx;
      logic [NODE_INDEX_W-1:0] pv;
      reply.status = STATUS_OK;
      if (op == OP_APPEND) begin
         if (int'(node) >= NODE_COUNT) begin
            reply.status = STATUS_ABSENT;
         end else if (member_map[node]) begin
            reply.status = STATUS_QUEUED;
         end else begin
            if (member_total == 0) begin
               head_idx = node;
               succ_node[node] = node;
               pred_node[node] = node;
            end else begin
               // The new node goes between the tail and the head.
               tail_idx = pred_node[head_idx];
               succ_node[node] = head_idx;
               pred_node[node] = tail_idx;
               succ_node[tail_idx] = node;
               pred_node[head_idx] = node;
            end
            member_map[node] = 1'b1;
            member_total++;
         end
      end else begin
         if (member_total == 0) begin
            reply.status = STATUS_EMPTY;
         end else if ((int'(node) >= NODE_COUNT) || !member_map[node]) begin
            reply.status = STATUS_ABSENT;
         end else begin
            if (member_total == 1) begin
               head_idx = '0;
            end else begin
               nx = succ_node[node];
               pv = pred_node[node];
               if (head_idx == node) head_idx = nx;
               pred_node[nx] = pv;
               succ_node[pv] = nx;
            end
            member_map[node] = 1'b0;
            member_total--;
         end
      end
      reply.member_count = MEMBER_COUNT_W'(member_total);
      reply.head_valid = (member_total != 0);
      reply.head_node = (member_total != 0) ? head_idx : '0;
      return reply;
   endfunction

   always @(posedge clock) begin : watch_beats
      queue_reply_type want;
      if (reset) begin
         member_map = '0;
         head_idx = '0;
         member_total = 0;
         mismatch_count = 0;
         expected_replies.delete();
      end else begin
         // Replies are retired before the new request is added, so a beat that
         // arrives with nothing outstanding is never matched to its own request.
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("response beat with no request outstanding");
            end else begin
               want = expected_replies.pop_front();
               check_field("status", rsp_status, want.status);
               check_field("member_count", rsp_member_count, want.member_count);
               check_field("head_node", rsp_head_node, want.head_node);
               check_field("head_valid", rsp_head_valid, want.head_valid);
            end
         end
         if (req_valid && req_ready) begin
            expected_replies.push_back(apply_queue_op(clqm_op_type'(req_operation),
                                                      req_node_index));
         end
      end
      replies_pending <= expected_replies.size();
   end

endmodule

/* bench/circular_linked_queue_manager_unit_tb.sv */
`timescale 1ns / 1ps

module circular_linked_queue_manager_unit_tb;
   import clqm_pkg::*;

   localparam int NODE_COUNT = NODE_COUNT_DEFAULT;
   localparam int RANDOM_ITEMS = 700;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;

   logic clock;
   logic reset = 1'b1;
   int   mismatch_count;
   int   replies_pending;
   int   idle_cycles = 0;

   // Membership as the stimulus sees it, used only to steer the random part.
   logic [NODE_COUNT-1:0] queued_nodes = '0;
   bit                    send_quiet = 1'b0;

   clqm_req_if req_bus ();
   clqm_rsp_if rsp_bus ();

   circular_linked_queue_manager_unit #(
      .NODE_COUNT(NODE_COUNT)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   clqm_queue_checker #(
      .NODE_COUNT(NODE_COUNT)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_operation   (req_bus.operation),
      .req_node_index  (req_bus.node_index),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_status      (rsp_bus.status),
      .rsp_member_count(rsp_bus.member_count),
      .rsp_head_node   (rsp_bus.head_node),
      .rsp_head_valid  (rsp_bus.head_valid),
      .replies_pending (replies_pending),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Valid stays high from one beat into the next when no gap is drawn.
   task automatic send_request(input clqm_op_type op, input logic [NODE_INDEX_W-1:0] node);
      int gap;
      if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
      gap = send_quiet ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.node_index <= node;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      queued_nodes[node] = (op == OP_APPEND);
   endtask

   function automatic logic [NODE_INDEX_W-1:0] pick_node(input bit want_member);
      logic [NODE_INDEX_W-1:0] node;
      node = NODE_INDEX_W'($urandom_range(0, NODE_COUNT - 1));
      repeat (NODE_COUNT) begin
         if (queued_nodes[node] == want_member) return node;
         node++;
      end
      return node;
   endfunction

   initial begin : response_side
      int stall;
      bit quiet;
      quiet = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) quiet = !quiet;
         stall = quiet ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   initial begin : request_side
      int  members;
      bit  draining;
      draining = 1'b0;
      req_bus.valid <= 1'b0;
      req_bus.operation <= OP_APPEND;
      req_bus.node_index <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty queue, duplicate, absent node, last removal, a full
      // pool, then removal of the head, the tail and a middle node.
      send_request(OP_REMOVE, 4'd15);
      send_request(OP_APPEND, 4'd5);
      send_request(OP_APPEND, 4'd5);
      send_request(OP_REMOVE, 4'd9);
      send_request(OP_REMOVE, 4'd5);
      for (int k = 0; k < NODE_COUNT; k++) begin
         send_request(OP_APPEND, NODE_INDEX_W'((k * 7 + 3) % NODE_COUNT));
      end
      send_request(OP_APPEND, 4'd12);
      send_request(OP_REMOVE, 4'd3);
      send_request(OP_REMOVE, 4'd12);
      send_request(OP_REMOVE, 4'd6);
      send_request(OP_REMOVE, 4'd6);

      // Random: mostly legal appends and removals that sweep the queue between
      // empty and full, with some arbitrary requests mixed in.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         members = $countones(queued_nodes);
         if (members == 0) draining = 1'b0;
         else if (members == NODE_COUNT) draining = 1'b1;
         else if ($urandom_range(0, 19) == 0) draining = !draining;
         if ($urandom_range(0, 9) < 8) begin
            if (draining) send_request(OP_REMOVE, pick_node(1'b1));
            else send_request(OP_APPEND, pick_node(1'b0));
         end else begin
            send_request(clqm_op_type'($urandom_range(0, 1)),
                         NODE_INDEX_W'($urandom_range(0, NODE_COUNT - 1)));
         end
      end
      req_bus.valid <= 1'b0;

      // The pending count is a registered copy of the checker's queue size, so it may lag the last request.
      @(posedge clock);
      while (replies_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* files.f */
src/clqm_pkg.sv
src/clqm_channels.sv
src/clqm_controller.sv
src/clqm_datapath.sv
src/circular_linked_queue_manager_unit.sv
bench/clqm_queue_checker.sv
bench/circular_linked_queue_manager_unit_tb.sv
